@@ rtl/tga_pkg.sv @@
// Shared types and constants for the TGA run-length image decoder.
package tga_pkg;

  // Result kinds carried on the output tuser
  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Image type codes in header byte 2
  localparam logic [7:0] TYPE_RAW = 8'h02;
  localparam logic [7:0] TYPE_RLE = 8'h0A;

  // Pixel sizes in header byte 16
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  // Header byte positions
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_FIXED    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP      = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

  // Packet header: values below this start a raw packet
  localparam logic [7:0] PKT_RUN_FLAG = 8'd128;
  localparam logic [7:0] PKT_RUN_BIAS = 8'd127;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Result queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Output tdata width: 73 payload bits padded to whole bytes
  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        end_of_image;
  } tga_result_t;

endpackage

@@ rtl/tga_front.sv @@
// Byte parser: header check, packet decode and pixel assembly.
module tga_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     start_of_file,
  output logic                     push,
  output tga_pkg::tga_result_t     result
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_PACKET = 5'b00100,
    PH_PIXEL  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  phase_t      phase, phase_next, phase_eff;
  logic [4:0]  header_index, hidx_eff;
  logic        run_length_mode;
  logic        alpha_present;
  logic [15:0] width_store;
  logic [15:0] height_store;
  logic [31:0] pixels_left;
  logic [7:0]  packet_left;
  logic        packet_is_run;
  logic [1:0]  channel_index;
  logic [7:0]  channel_bytes [3];

  logic        hdr_ok;
  logic        pix_done;
  logic [7:0]  cnt_raw;
  logic [7:0]  cnt;
  logic [31:0] pixels_after;
  logic [7:0]  packet_dec;
  logic [7:0]  red_byte;

  // Start flag restarts the parse at header byte zero
  assign phase_eff = start_of_file ? PH_HEADER : phase;
  assign hidx_eff  = start_of_file ? 5'd0 : header_index;

  // Fixed header bytes: type byte is raw or RLE, the rest zero
  assign hdr_ok = (hidx_eff == tga_pkg::HDR_TYPE)
                ? ((data_byte == tga_pkg::TYPE_RAW) || (data_byte == tga_pkg::TYPE_RLE))
                : (data_byte == 8'd0);

  // Pixel completes on the last channel byte
  assign pix_done = alpha_present ? (channel_index == 2'd3) : (channel_index == 2'd2);

  // Repeat count, clipped to the pixels that remain
  assign cnt_raw = packet_is_run ? packet_left : 8'd1;
  assign cnt = ((pixels_left[31:8] == 24'd0) && (cnt_raw > pixels_left[7:0]))
             ? pixels_left[7:0] : cnt_raw;
  assign pixels_after = pixels_left - {24'd0, cnt};
  assign packet_dec   = packet_left - 8'd1;
  assign red_byte     = (channel_index == 2'd2) ? data_byte : channel_bytes[2];

  // Decode one accepted byte into an optional result
  always_comb begin
    push       = 1'b0;
    result     = '0;
    phase_next = phase_eff;
    if (accept) begin
      unique case (phase_eff)
        PH_HEADER: begin
          if (hidx_eff < tga_pkg::HDR_FIXED) begin
            if (!hdr_ok) begin
              push          = 1'b1;
              result.status = tga_pkg::ST_REJECT;
              phase_next    = PH_DONE;
            end
          end else if (hidx_eff == tga_pkg::HDR_BPP) begin
            if ((data_byte != tga_pkg::BPP_24) && (data_byte != tga_pkg::BPP_32)) begin
              push          = 1'b1;
              result.status = tga_pkg::ST_REJECT;
              phase_next    = PH_DONE;
            end
          end else if (hidx_eff == tga_pkg::HDR_LAST) begin
            push                = 1'b1;
            result.status       = tga_pkg::ST_HEADER;
            result.image_width  = width_store;
            result.image_height = height_store;
            result.has_alpha    = alpha_present;
            if ((width_store == 16'd0) || (height_store == 16'd0)) begin
              result.end_of_image = 1'b1;
              phase_next          = PH_DONE;
            end else begin
              phase_next = run_length_mode ? PH_PACKET : PH_PIXEL;
            end
          end
        end
        PH_PACKET: begin
          phase_next = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (pix_done) begin
            push                = 1'b1;
            result.status       = tga_pkg::ST_PIXEL;
            result.red          = red_byte;
            result.green        = channel_bytes[1];
            result.blue         = channel_bytes[0];
            result.alpha        = alpha_present ? data_byte : tga_pkg::ALPHA_OPAQUE;
            result.repeat_count = cnt;
            if (pixels_after == 32'd0) begin
              result.end_of_image = 1'b1;
              phase_next          = PH_DONE;
            end else if (run_length_mode) begin
              if (packet_is_run || (packet_dec == 8'd0)) begin
                phase_next = PH_PACKET;
              end
            end
          end
        end
        PH_IDLE, PH_DONE: begin
          phase_next = phase_eff;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_index    <= 5'd0;
      run_length_mode <= 1'b0;
      alpha_present   <= 1'b0;
      pixels_left     <= 32'd0;
      packet_left     <= 8'd0;
      packet_is_run   <= 1'b0;
      channel_index   <= 2'd0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase_eff == PH_HEADER) begin
        header_index <= hidx_eff + 5'd1;
        if (hidx_eff == tga_pkg::HDR_TYPE) begin
          run_length_mode <= (data_byte == tga_pkg::TYPE_RLE);
        end
        if (hidx_eff == tga_pkg::HDR_BPP) begin
          alpha_present <= (data_byte == tga_pkg::BPP_32);
        end
        if (hidx_eff == tga_pkg::HDR_LAST) begin
          pixels_left   <= width_store * height_store;
          packet_left   <= 8'd0;
          packet_is_run <= 1'b0;
          channel_index <= 2'd0;
        end
      end else if (phase_eff == PH_PACKET) begin
        channel_index <= 2'd0;
        if (data_byte < tga_pkg::PKT_RUN_FLAG) begin
          packet_is_run <= 1'b0;
          packet_left   <= data_byte + 8'd1;
        end else begin
          packet_is_run <= 1'b1;
          packet_left   <= data_byte - tga_pkg::PKT_RUN_BIAS;
        end
      end else if (phase_eff == PH_PIXEL) begin
        if (pix_done) begin
          channel_index <= 2'd0;
          pixels_left   <= pixels_after;
          if (run_length_mode && !packet_is_run) begin
            packet_left <= packet_dec;
          end
        end else begin
          channel_index <= channel_index + 2'd1;
        end
      end
    end
  end

  // Header size bytes and held pixel channels
  always_ff @(posedge clk) begin
    if (accept && (phase_eff == PH_HEADER)) begin
      if (hidx_eff == tga_pkg::HDR_WIDTH_LO)  width_store[7:0]   <= data_byte;
      if (hidx_eff == tga_pkg::HDR_WIDTH_HI)  width_store[15:8]  <= data_byte;
      if (hidx_eff == tga_pkg::HDR_HEIGHT_LO) height_store[7:0]  <= data_byte;
      if (hidx_eff == tga_pkg::HDR_HEIGHT_HI) height_store[15:8] <= data_byte;
    end
    if (accept && (phase_eff == PH_PIXEL) && (channel_index != 2'd3)) begin
      channel_bytes[channel_index] <= data_byte;
    end
  end

endmodule

@@ rtl/tga_fifo.sv @@
// Short result queue between the parser and the output stage.
module tga_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tga_pkg::tga_result_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output tga_pkg::tga_result_t pop_data
);

  tga_pkg::tga_result_t          entries [tga_pkg::QUEUE_DEPTH];
  logic [tga_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [tga_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [tga_pkg::QUEUE_CW-1:0]  count;

  assign full      = (count == tga_pkg::QUEUE_CW'(tga_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/tga_back.sv @@
// Output register stage: drains the queue and packs results onto the stream.
module tga_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_not_empty,
  input  tga_pkg::tga_result_t                q_data,
  output logic                                q_pop,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tga_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  tga_pkg::tga_result_t held;
  logic                 load;

  // Load when the register is empty or its transaction completes
  assign load  = !m_axis_tvalid || m_axis_tready;
  assign q_pop = load && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) held <= q_data;
  end

  // Pack payload, first field lowest
  assign m_axis_tdata = {7'd0, held.has_alpha, held.image_height, held.image_width,
                         held.repeat_count, held.alpha, held.blue, held.green, held.red};
  assign m_axis_tuser = held.status;
  assign m_axis_tlast = held.end_of_image;

endmodule

@@ rtl/tga_rle_image_decoder_top.sv @@
// Top level of the TGA run-length image decoder.
// Takes one file byte per clock while the result queue has room, and yields header, reject and pixel results.
// Every byte is accepted in the cycle it is offered while the four-entry result
// queue has room; the parser decodes each byte as it is accepted, and each
// result passes the result queue, then the output register. Input stalls
// only once the queue fills behind a stalled output. Results: tuser 1 is the
// header (size and alpha flag), 2 a rejected format, 0 a pixel with its repeat
// count; tlast marks the result that completes the image. Bytes before a start
// flag and after the image ends give no result.
module tga_rle_image_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]                     s_axis_tuser,   // [0] start_of_file
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
  // [55:40] image_width, [71:56] image_height, [72] has_alpha, [79:73] zero
  output logic [tga_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,   // [1:0] status
  output logic                           m_axis_tlast    // end_of_image
);

  logic                 accept;
  logic                 push;
  tga_pkg::tga_result_t push_data;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;
  tga_pkg::tga_result_t q_data;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tga_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_axis_tdata),
    .start_of_file (s_axis_tuser[0]),
    .push          (push),
    .result        (push_data)
  );

  tga_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  tga_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ tb/tb_tga_rle_image_decoder_top.sv @@
// Self-checking testbench for the TGA run-length image decoder top level.
`timescale 1ns / 1ps

module tb_tga_rle_image_decoder_top;
  import tga_pkg::*;

  typedef enum logic [2:0] {
    P_WAIT,
    P_HEADER,
    P_PACKET,
    P_PIXEL,
    P_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } file_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic [0:0]            s_axis_tuser = 1'b0;   // [0] start_of_file
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
  // [55:40] image_width, [71:56] image_height, [72] has_alpha, [79:73] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;          // [1:0] status
  logic                  m_axis_tlast;          // end_of_image

  // Stimulus and scoreboard storage
  file_byte_t  file_bytes_q[$];
  tga_result_t pending_results[$];
  int          error_count = 0;
  int          sent_count = 0;
  bit          in_taken = 1'b0;
  int          idle_mode = 0;
  int          sender_idle_pct[4] = '{0, 70, 0, 33};
  int          receiver_stall_pct[4] = '{0, 0, 70, 33};

  // Shadow copy of the parser state
  parse_phase_t m_phase;
  logic [4:0]   m_hdr_idx;
  logic         m_rle;
  logic         m_alpha;
  logic [15:0]  m_width;
  logic [15:0]  m_height;
  logic [31:0]  m_pix_left;
  logic [7:0]   m_pkt_left;
  logic         m_pkt_is_run;
  logic [1:0]   m_chan_idx;
  logic [7:0]   m_chan [3];

  tga_rle_image_decoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reset held at start, released on a falling edge
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Clear the shadow parser state
  function automatic void clear_decoder();
    m_phase      = P_WAIT;
    m_hdr_idx    = '0;
    m_rle        = 1'b0;
    m_alpha      = 1'b0;
    m_width      = '0;
    m_height     = '0;
    m_pix_left   = '0;
    m_pkt_left   = '0;
    m_pkt_is_run = 1'b0;
    m_chan_idx   = '0;
    for (int i = 0; i < 3; i++) m_chan[i] = '0;
  endfunction

  initial clear_decoder();

  // Advance the shadow parser by one file byte; return 1 when a result is due
  function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                     output tga_result_t res);
    logic [4:0]  idx;
    logic [1:0]  ci;
    logic [31:0] cnt;
    int          need;
    bit          ok;
    res = '0;
    if (sof) begin
      clear_decoder();
      m_phase = P_HEADER;
    end
    case (m_phase)
      P_HEADER: begin
        idx = m_hdr_idx;
        m_hdr_idx = m_hdr_idx + 5'd1;
        // Fixed part: zeros except the image type
        if (idx < HDR_FIXED) begin
          if (idx == HDR_TYPE) begin
            ok = (b == TYPE_RAW) || (b == TYPE_RLE);
            m_rle = (b == TYPE_RLE);
          end else begin
            ok = (b == 8'h00);
          end
          if (!ok) begin
            res.status = ST_REJECT;
            m_phase = P_DONE;
            return 1'b1;
          end
          return 1'b0;
        end
        if (idx != HDR_LAST) begin
          case (idx)
            HDR_WIDTH_LO:  m_width[7:0] = b;
            HDR_WIDTH_HI:  m_width[15:8] = b;
            HDR_HEIGHT_LO: m_height[7:0] = b;
            HDR_HEIGHT_HI: m_height[15:8] = b;
            HDR_BPP: begin
              if (b != BPP_24 && b != BPP_32) begin
                res.status = ST_REJECT;
                m_phase = P_DONE;
                return 1'b1;
              end
              m_alpha = (b == BPP_32);
            end
            default: ;
          endcase
          return 1'b0;
        end
        // Last header byte: report the image size
        m_pix_left = 32'(m_width) * 32'(m_height);
        res.status = ST_HEADER;
        res.image_width = m_width;
        res.image_height = m_height;
        res.has_alpha = m_alpha;
        m_chan_idx = '0;
        m_pkt_is_run = 1'b0;
        m_pkt_left = '0;
        if (m_pix_left == 32'd0) begin
          res.end_of_image = 1'b1;
          m_phase = P_DONE;
        end else begin
          m_phase = m_rle ? P_PACKET : P_PIXEL;
        end
        return 1'b1;
      end
      P_PACKET: begin
        if (b < PKT_RUN_FLAG) begin
          m_pkt_is_run = 1'b0;
          m_pkt_left = b + 8'd1;
        end else begin
          m_pkt_is_run = 1'b1;
          m_pkt_left = b - PKT_RUN_BIAS;
        end
        m_chan_idx = '0;
        m_phase = P_PIXEL;
        return 1'b0;
      end
      P_PIXEL: begin
        need = m_alpha ? 4 : 3;
        ci = m_chan_idx;
        if (ci < 2'd3) m_chan[ci] = b;
        if (int'(ci) + 1 < need) begin
          m_chan_idx = ci + 2'd1;
          return 1'b0;
        end
        // Pixel complete: clip the count to what remains
        m_chan_idx = '0;
        cnt = m_pkt_is_run ? 32'(m_pkt_left) : 32'd1;
        if (cnt > m_pix_left) cnt = m_pix_left;
        m_pix_left = m_pix_left - cnt;
        res.status = ST_PIXEL;
        res.red = m_chan[2];
        res.green = m_chan[1];
        res.blue = m_chan[0];
        res.alpha = m_alpha ? b : ALPHA_OPAQUE;
        res.repeat_count = cnt[7:0];
        if (m_pix_left == 32'd0) begin
          res.end_of_image = 1'b1;
          m_phase = P_DONE;
        end else if (m_rle) begin
          if (m_pkt_is_run) begin
            m_phase = P_PACKET;
          end else begin
            m_pkt_left = m_pkt_left - 8'd1;
            if (m_pkt_left == 8'd0) m_phase = P_PACKET;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin : monitor
    tga_result_t res;
    tga_result_t got;
    tga_result_t want;
    in_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (in_taken && decode_byte(s_axis_tdata, s_axis_tuser[0], res))
      pending_results.push_back(res);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status       = m_axis_tuser;
      got.red          = m_axis_tdata[7:0];
      got.green        = m_axis_tdata[15:8];
      got.blue         = m_axis_tdata[23:16];
      got.alpha        = m_axis_tdata[31:24];
      got.repeat_count = m_axis_tdata[39:32];
      got.image_width  = m_axis_tdata[55:40];
      got.image_height = m_axis_tdata[71:56];
      got.has_alpha    = m_axis_tdata[72];
      got.end_of_image = m_axis_tlast;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, actual status %0d",
                 $time, got.status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("red", 16'(want.red), 16'(got.red));
        check_field("green", 16'(want.green), 16'(got.green));
        check_field("blue", 16'(want.blue), 16'(got.blue));
        check_field("alpha", 16'(want.alpha), 16'(got.alpha));
        check_field("repeat_count", 16'(want.repeat_count), 16'(got.repeat_count));
        check_field("image_width", want.image_width, got.image_width);
        check_field("image_height", want.image_height, got.image_height);
        check_field("has_alpha", 16'(want.has_alpha), 16'(got.has_alpha));
        check_field("end_of_image", 16'(want.end_of_image), 16'(got.end_of_image));
      end
    end
  end

  // Driver: present the next byte once the previous one is taken
  always @(negedge clk) begin : driver
    file_byte_t nxt;
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct[idle_mode]);
    if (!s_axis_tvalid || in_taken) begin
      if (!rst && file_bytes_q.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct[idle_mode]) begin
        nxt = file_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tuser  <= nxt.sof;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic sof);
    file_bytes_q.push_back('{data: data, sof: sof});
    sent_count++;
  endtask

  // Header image, byte i at bits [8*i +: 8]
  function automatic logic [143:0] make_header(input logic rle, input logic [7:0] bpp,
                                               input logic [15:0] w, input logic [15:0] h,
                                               input logic [7:0] tail);
    logic [143:0] hdr;
    hdr = '0;
    hdr[HDR_TYPE * 8 +: 8]      = rle ? TYPE_RLE : TYPE_RAW;
    hdr[HDR_WIDTH_LO * 8 +: 8]  = w[7:0];
    hdr[HDR_WIDTH_HI * 8 +: 8]  = w[15:8];
    hdr[HDR_HEIGHT_LO * 8 +: 8] = h[7:0];
    hdr[HDR_HEIGHT_HI * 8 +: 8] = h[15:8];
    hdr[HDR_BPP * 8 +: 8]       = bpp;
    hdr[HDR_LAST * 8 +: 8]      = tail;
    return hdr;
  endfunction

  task automatic push_header(input logic [143:0] hdr, input int n);
    for (int i = 0; i < n; i++) push_byte(hdr[i * 8 +: 8], i == 0);
  endtask

  // Noise after a file: ignored by the parser
  task automatic push_trailing();
    int k;
    k = $urandom_range(0, 3);
    for (int i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Queue one random file: mostly well-formed, some broken or cut short
  task automatic add_file();
    logic [143:0] hdr;
    logic         rle;
    logic [7:0]   bpp;
    logic [7:0]   bad;
    logic [15:0]  w;
    logic [15:0]  h;
    logic [31:0]  rem;
    logic [31:0]  take;
    int           kind;
    int           sel;
    int           idx;
    int           budget;
    int           cnt;
    int           npx;
    int           bpx;
    bit           run;
    bit           cut;
    kind = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    rle  = 1'($urandom_range(0, 1));
    bpp  = $urandom_range(0, 1) ? BPP_32 : BPP_24;
    cut  = 1'b0;
    if (sel < 6) begin
      w = 16'($urandom_range(0, 65535));
      h = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1)) w = '0;
      else h = '0;
    end else if (sel < 11) begin
      w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(256, 65535));
      h = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      cut = 1'b1;
    end else if (sel < 22 && rle) begin
      w = 16'($urandom_range(1, 16));
      h = 16'($urandom_range(1, 16));
    end else begin
      w = 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 4));
    end
    hdr = make_header(rle, bpp, w, h, 8'($urandom_range(0, 255)));

    // Broken fixed header bytes
    if (kind < 7) begin
      idx = $urandom_range(0, 11);
      if (idx == HDR_TYPE) begin
        bad = 8'($urandom_range(0, 255));
        if (bad == TYPE_RAW || bad == TYPE_RLE) bad = bad + 8'd1;
      end else begin
        bad = 8'($urandom_range(1, 255));
      end
      hdr[idx * 8 +: 8] = bad;
      push_header(hdr, idx + 1);
      push_trailing();
      return;
    end
    // Unsupported pixel size
    if (kind < 12) begin
      bad = 8'($urandom_range(0, 255));
      if (bad == BPP_24 || bad == BPP_32) bad = bad + 8'd1;
      hdr[HDR_BPP * 8 +: 8] = bad;
      push_header(hdr, 18);
      push_trailing();
      return;
    end
    // Header cut short by the next start flag
    if (kind < 16) begin
      push_header(hdr, $urandom_range(1, 17));
      return;
    end

    push_header(hdr, 18);
    rem = 32'(w) * 32'(h);
    if (rem == 32'd0) begin
      push_trailing();
      return;
    end
    if ($urandom_range(0, 99) < 8) cut = 1'b1;
    budget = cut ? $urandom_range(0, 40) : 32'h7FFF_FFFF;
    bpx = (bpp == BPP_32) ? 4 : 3;
    while (rem != 0 && budget > 0) begin
      npx = 1;
      if (rle) begin
        run = 1'($urandom_range(0, 1));
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        push_byte(run ? 8'(127 + cnt) : 8'(cnt - 1), 1'b0);
        budget--;
        take = (32'(cnt) > rem) ? rem : 32'(cnt);
        npx = run ? 1 : int'(take);
        rem = rem - take;
      end else begin
        rem = rem - 32'd1;
      end
      for (int p = 0; p < npx * bpx; p++) begin
        if (budget > 0) begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
          budget--;
        end
      end
    end
    if (!cut && $urandom_range(0, 9) < 3) push_trailing();
  endtask

  // Wait until every queued byte is taken and every result has arrived
  task automatic drain();
    while (file_bytes_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0) begin
      @(negedge clk);
      #1;
    end
  endtask

  // Stimulus sequence and end of run
  initial begin
    while (rst) @(negedge clk);

    // Bytes before any start flag
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // Bad first byte, then a byte that must be ignored
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    // Unknown image type
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0);
    // Empty image: zero width, maximum height
    push_header(make_header(1'b1, BPP_32, 16'h0000, 16'hFFFF, 8'hFF), 18);
    drain();

    // Random files under each idling pattern
    for (int seg = 0; seg < 8; seg++) begin
      int target;
      idle_mode = seg % 4;
      target = sent_count + 140;
      while (sent_count < target) add_file();
      drain();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tga_rle_image_decoder_top verification clean");
    end else begin
      $display("tga_rle_image_decoder_top verification failed");
    end
    $finish;
  end

  // Hard limit on run length
  initial begin
    #(12 * 400000);
    $display("tga_rle_image_decoder_top verification failed");
    $finish;
  end

endmodule
